@@ src/dltq_pkg.sv @@
`timescale 1ns / 1ps

package dltq_pkg;

    localparam int ID_W     = 6;
    localparam int ID_COUNT = 2 ** ID_W;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_QUEUED,
        STATUS_NOT_QUEUED
    } status_t;

    typedef enum logic {
        KIND_INSERT,
        KIND_REMOVE
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_W_ID,
        ST_INS_W_CUR,
        ST_INS_W_PREV,
        ST_RM_SELF,
        ST_RM_WALK,
        ST_RM_NXT,
        ST_RM_W_NXT,
        ST_RM_W_PREV,
        ST_DONE
    } state_t;

endpackage

@@ src/delta_list_timer_queue_unit.sv @@
// Sequence: an insert walks the list from the head to its place, then writes its own entry,
//   its follower and its predecessor or the head; a remove reads its own entry, walks back to
//   the head to count its position, then rewrites its follower (unless it is the tail) and predecessor.
// Throughput: one item at a time, one list entry a cycle through the single-port-read
//   entry memory.
// Reset: synchronous, active low; empties the list and clears the queued marks. The entry
//   memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module delta_list_timer_queue_unit
    import dltq_pkg::*;
#(
    parameter int MAX_THREADS = 64,
    parameter int DELAY_BITS  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [0:0]          s_kind,
    input  logic [ID_W-1:0]     s_thread_id,
    input  logic [TICK_W-1:0]   s_sleep_ticks,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [POS_W-1:0]    m_position,
    output logic [TICK_W-1:0]   m_stored_delta
);

    localparam int IDX_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int LINK_W = $clog2(MAX_THREADS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_THREADS);

    typedef struct packed {
        logic [LINK_W-1:0]     nxt;
        logic [LINK_W-1:0]     prv;
        logic [DELAY_BITS-1:0] delta;
    } word_t;

    // entry memory
    word_t entry_mem [MAX_THREADS];
    word_t rd_data_reg;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    word_t            mem_wdata;

    // control state
    state_t              state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   entry_count_reg, entry_count_next;
    logic [ID_COUNT-1:0] queued_reg, queued_next;
    logic                m_valid_reg, m_valid_next;

    // working registers
    logic [ID_W-1:0]       id_reg, id_next;
    logic [DELAY_BITS-1:0] rem_reg, rem_next;
    logic [LINK_W-1:0]     pos_reg, pos_next;
    logic [LINK_W-1:0]     prev_reg, prev_next;
    logic [LINK_W-1:0]     cur_reg, cur_next;
    status_t               status_reg, status_next;
    word_t                 prev_word_reg, prev_word_next;
    word_t                 self_word_reg, self_word_next;
    status_t               m_status_reg, m_status_next;
    logic [LINK_W-1:0]     m_pos_reg, m_pos_next;
    logic [TICK_W-1:0]     m_delta_reg, m_delta_next;

    logic                  accept;
    logic                  out_free;
    logic [LINK_W-1:0]     pos_inc;
    logic [LINK_W-1:0]     id_link;
    logic [IDX_W-1:0]      id_addr;
    logic [DELAY_BITS:0]   sum_w;
    logic [DELAY_BITS-1:0] sum_sat;
    logic                  walk_stop;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_position     = POS_W'(m_pos_reg);
    assign m_stored_delta = m_delta_reg;

    assign pos_inc   = pos_reg + LINK_W'(1);
    assign id_link   = LINK_W'(id_reg);
    assign id_addr   = IDX_W'(id_reg);
    assign sum_w     = {1'b0, rd_data_reg.delta} + {1'b0, self_word_reg.delta};
    assign sum_sat   = sum_w[DELAY_BITS] ? '1 : sum_w[DELAY_BITS-1:0];
    assign walk_stop = (rd_data_reg.nxt >= NIL) || (pos_inc >= NIL);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_INSERT) begin
                        if (s_thread_id >= MAX_THREADS || queued_reg[s_thread_id]
                            || entry_count_reg >= NIL) begin
                            state_next = ST_DONE;
                        end else if (head_reg < NIL) begin
                            state_next = ST_INS_WALK;
                        end else begin
                            state_next = ST_INS_W_ID;
                        end
                    end else begin
                        if (s_thread_id >= MAX_THREADS || !queued_reg[s_thread_id]) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_RM_SELF;
                        end
                    end
                end
            end
            ST_INS_WALK: begin
                if (rem_reg < rd_data_reg.delta || walk_stop) begin
                    state_next = ST_INS_W_ID;
                end
            end
            ST_INS_W_ID:   state_next = ST_INS_W_CUR;
            ST_INS_W_CUR:  state_next = ST_INS_W_PREV;
            ST_INS_W_PREV: state_next = ST_DONE;
            ST_RM_SELF: begin
                state_next = (rd_data_reg.prv < NIL) ? ST_RM_WALK : ST_RM_NXT;
            end
            ST_RM_WALK: begin
                if (rd_data_reg.prv >= NIL || pos_inc >= NIL) begin
                    state_next = ST_RM_NXT;
                end
            end
            ST_RM_NXT: begin
                state_next = (self_word_reg.nxt < NIL) ? ST_RM_W_NXT : ST_RM_W_PREV;
            end
            ST_RM_W_NXT:  state_next = ST_RM_W_PREV;
            ST_RM_W_PREV: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        head_next        = head_reg;
        entry_count_next = entry_count_reg;
        queued_next      = queued_reg;
        m_valid_next     = m_valid_reg;
        id_next          = id_reg;
        rem_next         = rem_reg;
        pos_next         = pos_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        status_next      = status_reg;
        prev_word_next   = prev_word_reg;
        self_word_next   = self_word_reg;
        m_status_next    = m_status_reg;
        m_pos_next       = m_pos_reg;
        m_delta_next     = m_delta_reg;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    id_next     = s_thread_id;
                    pos_next    = '0;
                    prev_next   = NIL;
                    cur_next    = head_reg;
                    status_next = STATUS_OK;
                    if (s_kind == KIND_INSERT) begin
                        rem_next = DELAY_BITS'(s_sleep_ticks);
                        if (s_thread_id >= MAX_THREADS) begin
                            status_next = STATUS_FULL;
                            rem_next    = '0;
                        end else if (queued_reg[s_thread_id]) begin
                            status_next = STATUS_QUEUED;
                            rem_next    = '0;
                        end else if (entry_count_reg >= NIL) begin
                            status_next = STATUS_FULL;
                            rem_next    = '0;
                        end else if (head_reg < NIL) begin
                            mem_re    = 1'b1;
                            mem_raddr = head_reg[IDX_W-1:0];
                        end
                    end else begin
                        rem_next = '0;
                        if (s_thread_id >= MAX_THREADS || !queued_reg[s_thread_id]) begin
                            status_next = STATUS_NOT_QUEUED;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = IDX_W'(s_thread_id);
                        end
                    end
                end
            end
            ST_INS_WALK: begin
                // step past this entry unless the remaining delay lands ahead of it
                if (!(rem_reg < rd_data_reg.delta)) begin
                    rem_next       = rem_reg - rd_data_reg.delta;
                    prev_next      = cur_reg;
                    prev_word_next = rd_data_reg;
                    cur_next       = rd_data_reg.nxt;
                    pos_next       = pos_inc;
                    if (!walk_stop) begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_data_reg.nxt[IDX_W-1:0];
                    end
                end
            end
            ST_INS_W_ID: begin
                mem_we          = 1'b1;
                mem_waddr       = id_addr;
                mem_wdata.nxt   = (cur_reg < NIL) ? cur_reg : NIL;
                mem_wdata.prv   = prev_reg;
                mem_wdata.delta = rem_reg;
            end
            ST_INS_W_CUR: begin
                // follower word is still held in the read register
                if (cur_reg < NIL) begin
                    mem_we          = 1'b1;
                    mem_waddr       = cur_reg[IDX_W-1:0];
                    mem_wdata.nxt   = rd_data_reg.nxt;
                    mem_wdata.prv   = id_link;
                    mem_wdata.delta = rd_data_reg.delta - rem_reg;
                end
            end
            ST_INS_W_PREV: begin
                if (prev_reg < NIL) begin
                    mem_we          = 1'b1;
                    mem_waddr       = prev_reg[IDX_W-1:0];
                    mem_wdata.nxt   = id_link;
                    mem_wdata.prv   = prev_word_reg.prv;
                    mem_wdata.delta = prev_word_reg.delta;
                end else begin
                    head_next = id_link;
                end
                queued_next[id_reg] = 1'b1;
                entry_count_next    = entry_count_reg + LINK_W'(1);
            end
            ST_RM_SELF: begin
                self_word_next = rd_data_reg;
                prev_next      = rd_data_reg.prv;
                if (rd_data_reg.prv < NIL) begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_data_reg.prv[IDX_W-1:0];
                end
            end
            ST_RM_WALK: begin
                // count back to the head; the first word read is the predecessor
                if (pos_reg == '0) begin
                    prev_word_next = rd_data_reg;
                end
                pos_next = pos_inc;
                if (rd_data_reg.prv < NIL && pos_inc < NIL) begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_data_reg.prv[IDX_W-1:0];
                end
            end
            ST_RM_NXT: begin
                if (self_word_reg.nxt < NIL) begin
                    mem_re    = 1'b1;
                    mem_raddr = self_word_reg.nxt[IDX_W-1:0];
                end
            end
            ST_RM_W_NXT: begin
                mem_we          = 1'b1;
                mem_waddr       = self_word_reg.nxt[IDX_W-1:0];
                mem_wdata.nxt   = rd_data_reg.nxt;
                mem_wdata.prv   = prev_reg;
                mem_wdata.delta = sum_sat;
                rem_next        = sum_sat;
            end
            ST_RM_W_PREV: begin
                if (prev_reg < NIL) begin
                    mem_we          = 1'b1;
                    mem_waddr       = prev_reg[IDX_W-1:0];
                    mem_wdata.nxt   = (self_word_reg.nxt < NIL) ? self_word_reg.nxt : NIL;
                    mem_wdata.prv   = prev_word_reg.prv;
                    mem_wdata.delta = prev_word_reg.delta;
                end else begin
                    head_next = (self_word_reg.nxt < NIL) ? self_word_reg.nxt : NIL;
                end
                queued_next[id_reg] = 1'b0;
                if (entry_count_reg != '0) begin
                    entry_count_next = entry_count_reg - LINK_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pos_next    = (status_reg == STATUS_OK) ? pos_reg : '0;
                    m_delta_next  = TICK_W'(rem_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            head_reg        <= NIL;
            entry_count_reg <= '0;
            queued_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            entry_count_reg <= entry_count_next;
            queued_reg      <= queued_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        status_reg    <= status_next;
        prev_word_reg <= prev_word_next;
        self_word_reg <= self_word_next;
        m_status_reg  <= m_status_next;
        m_pos_reg     <= m_pos_next;
        m_delta_reg   <= m_delta_next;
    end

`ifndef SYNTH
    a_count_matches_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(queued_reg) == int'(entry_count_reg))
        else $error("entry count disagrees with queued marks");

    a_empty_iff_no_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_count_reg == '0) == (head_reg == NIL))
        else $error("head link disagrees with entry count");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= NIL)
        else $error("entry count beyond list capacity");

    a_error_beat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_position == '0 && m_stored_delta == '0)
        else $error("error beat carries position or delta");
`endif

endmodule
